>>> rtl/cartridge_bank_mapper_macros.svh
// ----------------------------------------------------------------------------
// Cartridge bank mapper assertion macros
// Shared assertion wrappers for the bank mapper checker.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_MACROS_SVH

// checked only outside reset
`define CBM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CBM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Types, register indexes and decode constants shared by the mapper files.
// ----------------------------------------------------------------------------
package cbm_pkg;

   localparam int OFFSET_W = 16;
   localparam int DATA_W   = 8;
   localparam int TADDR_W  = 14;
   localparam int PAGE_W   = 5;
   localparam int TYPE_W   = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 48;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CART_TYPE  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROM_IS_64K = 8'd1;

   // special mapper type words
   localparam logic [TYPE_W-1:0] TYPE_ABSOLUTE = 16'h0200;
   localparam logic [TYPE_W-1:0] TYPE_LOW_SEL  = 16'h0100;

   // type word bits
   localparam int TYPE_BIT_SOUND = 0;
   localparam int TYPE_BIT_SUPER = 1;
   localparam int TYPE_BIT_RAM   = 2;

   localparam logic [OFFSET_W-1:0] OFF_BANK_SEL = 16'h4000;
   localparam logic [OFFSET_W-1:0] OFF_LOW_SEL  = 16'hBF80;

   localparam logic [PAGE_W-1:0] PAGE_A_RESET = 5'd2;
   localparam logic [PAGE_W-1:0] PAGE_B_RESET = 5'd4;
   localparam logic [PAGE_W-1:0] PAGE_C_RESET = 5'd5;
   localparam logic [PAGE_W-1:0] PAGE_D_RESET = 5'd6;
   localparam logic [PAGE_W-1:0] PAGE_IMAGE   = 5'd8;   // first page of image at $10000
   localparam logic [PAGE_W-1:0] PAGE_IMAGE_2 = 5'd10;

   typedef enum logic [1:0] {
      TGT_NONE  = 2'd0,
      TGT_RAM   = 2'd1,
      TGT_SOUND = 2'd2,
      TGT_UNDEF = 2'd3
   } target_type;

   typedef struct packed {
      logic [PAGE_W-1:0] a;
      logic [PAGE_W-1:0] b;
      logic [PAGE_W-1:0] c;
      logic [PAGE_W-1:0] d;
   } pages_type;

   typedef struct packed {
      target_type         target;
      logic [TADDR_W-1:0] addr;
      logic [DATA_W-1:0]  data;
   } route_type;

endpackage

>>> rtl/cbm_decode.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper decode
// Routes one write and works out the window pages it leaves behind.
// ----------------------------------------------------------------------------
module cbm_decode (
   input  logic [cbm_pkg::OFFSET_W-1:0] offset,
   input  logic [cbm_pkg::DATA_W-1:0]   data,
   input  logic [cbm_pkg::TYPE_W-1:0]   cart_type,
   input  logic                         rom_is_64k,
   input  cbm_pkg::pages_type           pages_cur,
   output cbm_pkg::pages_type           pages_nxt,
   output cbm_pkg::route_type           route
);

   logic                         low_space;
   logic [2:0]                   super_bank;
   logic [cbm_pkg::PAGE_W-1:0]   super_base;
   logic [cbm_pkg::PAGE_W-1:0]   low_base;

   assign low_space  = (offset[15:14] == 2'b00);
   assign super_bank = data[2:0] & {~rom_is_64k, 2'b11};
   assign super_base = cbm_pkg::PAGE_IMAGE + {1'b0, super_bank, 1'b0};
   assign low_base   = cbm_pkg::PAGE_IMAGE + {1'b0, offset[2:0], 1'b0};

   always_comb begin
      route = '0;
      route.target = cbm_pkg::TGT_NONE;
      if (low_space) begin
         if (cart_type[cbm_pkg::TYPE_BIT_RAM]) begin
            route.target = cbm_pkg::TGT_RAM;
         end else if (cart_type[cbm_pkg::TYPE_BIT_SOUND]) begin
            route.target = cbm_pkg::TGT_SOUND;
         end else begin
            route.target = cbm_pkg::TGT_UNDEF;
         end
         route.addr = offset[cbm_pkg::TADDR_W-1:0];
         route.data = data;
      end
   end

   // supercart first, then absolute, then low-address select
   always_comb begin
      pages_nxt = pages_cur;
      if (cart_type[cbm_pkg::TYPE_BIT_SUPER] && !low_space) begin
         pages_nxt.b = super_base;
         pages_nxt.c = super_base + 5'd1;
      end else if (cart_type == cbm_pkg::TYPE_ABSOLUTE && offset == cbm_pkg::OFF_BANK_SEL) begin
         if (data[0]) begin
            pages_nxt.a = cbm_pkg::PAGE_IMAGE;
         end else if (data[1]) begin
            pages_nxt.a = cbm_pkg::PAGE_IMAGE_2;
         end
      end else if (cart_type == cbm_pkg::TYPE_LOW_SEL && offset >= cbm_pkg::OFF_LOW_SEL) begin
         pages_nxt.c = low_base;
         pages_nxt.d = low_base + 5'd1;
      end
   end

endmodule

>>> rtl/cartridge_bank_mapper.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper
// Routes CPU writes into cartridge space and tracks the four window pages.
// ----------------------------------------------------------------------------
//  channel   dir   handshake             payload
//  req_      in    req_tvalid/tready     offset, data
//  rsp_      out   rsp_tvalid/tready     routing and four window pages
//  csr_      in    csr_valid/csr_ready   register index, write data
//
//  One request per cycle while req_tready is high; its response appears in the
//  cycle after acceptance, from the output register. Page registers update at acceptance.
//  req_tready is high while the output register is empty or being drained.
//  Synchronous reset: pages return to 2/4/5/6, type registers to zero.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [15:0] write_offset, [23:16] write_data
   input  logic [cbm_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] write_target, [15:2] target_address, [23:16] target_data,
   // [28:24] window_a_page, [33:29] window_b_page, [38:34] window_c_page,
   // [43:39] window_d_page, [47:44] zero
   output logic [cbm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cbm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic [cbm_pkg::TYPE_W-1:0] cart_type_ff;
   logic                       rom_is_64k_ff;
   cbm_pkg::pages_type         pages_ff, pages_in;
   cbm_pkg::route_type         route_in, route_ff;
   cbm_pkg::pages_type         rsp_pages_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       req_fire;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   cbm_decode u_decode (
      .offset     (req_tdata[15:0]),
      .data       (req_tdata[23:16]),
      .cart_type  (cart_type_ff),
      .rom_is_64k (rom_is_64k_ff),
      .pages_cur  (pages_ff),
      .pages_nxt  (pages_in),
      .route      (route_in)
   );

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_type_ff  <= '0;
         rom_is_64k_ff <= 1'b0;
         pages_ff      <= '{a: cbm_pkg::PAGE_A_RESET, b: cbm_pkg::PAGE_B_RESET,
                            c: cbm_pkg::PAGE_C_RESET, d: cbm_pkg::PAGE_D_RESET};
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               cbm_pkg::CSR_CART_TYPE:  cart_type_ff  <= csr_data;
               cbm_pkg::CSR_ROM_IS_64K: rom_is_64k_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (req_fire) begin
            pages_ff <= pages_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         route_ff     <= route_in;
         rsp_pages_ff <= pages_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_pages_ff.d, rsp_pages_ff.c, rsp_pages_ff.b,
                        rsp_pages_ff.a, route_ff.data, route_ff.addr, route_ff.target};

endmodule

>>> rtl/cbm_checker.sv
// ----------------------------------------------------------------------------
// Cartridge bank mapper checker
// Port-level checks on request/response timing and response contents.
// ----------------------------------------------------------------------------
`include "cartridge_bank_mapper_macros.svh"

module cbm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cbm_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   `CBM_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "response after reset")
   `CBM_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   `CBM_ASSERT(a_req_to_rsp, clock, reset, req_tvalid && req_tready |=> rsp_tvalid, "accepted request gave no response")
   `CBM_ASSERT(a_unrouted_zero, clock, reset, rsp_tvalid && rsp_tdata[1:0] == 2'd0 |-> rsp_tdata[23:2] == 22'd0, "unrouted write carries address or data")
   `CBM_ASSERT(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready, "request stalled with empty output")

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
